// File: hw/rtl/key_to_matrix_row_mapper_top_defines.svh
// ----------------------------------------------------------------------------
// key_to_matrix_row_mapper_top_defines.svh
// assertion macros used by the checker file of the key matrix mapper
// ----------------------------------------------------------------------------
`ifndef KEY_TO_MATRIX_ROW_MAPPER_TOP_DEFINES_SVH
`define KEY_TO_MATRIX_ROW_MAPPER_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define KMR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define KMR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/kmr_pkg.sv
// ----------------------------------------------------------------------------
// kmr_pkg
// types, codes and the key table of the key matrix mapper
// ----------------------------------------------------------------------------
package kmr_pkg;

    localparam int MODE_W    = 2;
    localparam int CODE_W    = 8;
    localparam int ROW_W     = 3;
    localparam int DATA_W    = 8;
    localparam int ROW_COUNT = 8;

    localparam logic [MODE_W-1:0] MODE_PRESS   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd3;

    localparam logic [DATA_W-1:0] ROW_RESET = 8'hff;

    localparam int OPQ_DEPTH = 2;
    localparam int OPQ_PTR_W = (OPQ_DEPTH > 1) ? $clog2(OPQ_DEPTH) : 1;
    localparam int OPQ_CNT_W = $clog2(OPQ_DEPTH + 1);

    typedef struct packed {
        logic              hit;
        logic [ROW_W-1:0]  row_a;
        logic [DATA_W-1:0] mask_a;
        logic              has_b;
        logic [ROW_W-1:0]  row_b;
        logic [DATA_W-1:0] mask_b;
    } t_key_entry;

    // classified operation passed from front to back
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ROW_W-1:0]  port_index;
        logic [ROW_W-1:0]  row_a;
        logic [DATA_W-1:0] mask_a;
        logic              has_b;
        logic [ROW_W-1:0]  row_b;
        logic [DATA_W-1:0] mask_b;
    } t_op;

    function automatic t_key_entry key_pair(input logic [ROW_W-1:0] ra,
                                            input logic [DATA_W-1:0] ma,
                                            input logic [ROW_W-1:0] rb,
                                            input logic [DATA_W-1:0] mb);
        t_key_entry e;
        e.hit    = 1'b1;
        e.row_a  = ra;
        e.mask_a = ma;
        e.has_b  = 1'b1;
        e.row_b  = rb;
        e.mask_b = mb;
        return e;
    endfunction

    function automatic t_key_entry key_single(input logic [ROW_W-1:0] ra,
                                              input logic [DATA_W-1:0] ma);
        t_key_entry e;
        e.hit    = 1'b1;
        e.row_a  = ra;
        e.mask_a = ma;
        e.has_b  = 1'b0;
        e.row_b  = '0;
        e.mask_b = ROW_RESET;
        return e;
    endfunction

    function automatic t_key_entry key_lookup(input logic [CODE_W-1:0] code);
        t_key_entry e;
        e = '{hit: 1'b0, row_a: '0, mask_a: ROW_RESET, has_b: 1'b0,
              row_b: '0, mask_b: ROW_RESET};
        unique case (code)
            // shifted control keys
            8'h01: e = key_pair(3'd3, 8'hfe, 3'd0, 8'hfe);
            8'h02: e = key_pair(3'd3, 8'hf7, 3'd0, 8'hfe);
            8'h03: e = key_pair(3'd4, 8'hfd, 3'd0, 8'hfe);
            8'h04: e = key_pair(3'd3, 8'hef, 3'd0, 8'hfe);
            8'h05: e = key_pair(3'd4, 8'hf7, 3'd0, 8'hfe);
            8'h06: e = key_pair(3'd4, 8'hef, 3'd0, 8'hfe);
            8'h07: e = key_pair(3'd4, 8'hfb, 3'd0, 8'hfe);
            8'h08: e = key_pair(3'd0, 8'hfe, 3'd4, 8'hfe);
            // digits
            8'h31: e = key_single(3'd3, 8'hfe);
            8'h32: e = key_single(3'd3, 8'hfd);
            8'h33: e = key_single(3'd3, 8'hfb);
            8'h34: e = key_single(3'd3, 8'hf7);
            8'h35: e = key_single(3'd3, 8'hef);
            8'h36: e = key_single(3'd4, 8'hef);
            8'h37: e = key_single(3'd4, 8'hf7);
            8'h38: e = key_single(3'd4, 8'hfb);
            8'h39: e = key_single(3'd4, 8'hfd);
            8'h30: e = key_single(3'd4, 8'hfe);
            // symbol shift over digits
            8'h21: e = key_pair(3'd3, 8'hfe, 3'd0, 8'hfd);
            8'h40: e = key_pair(3'd3, 8'hfd, 3'd0, 8'hfd);
            8'h23: e = key_pair(3'd3, 8'hfb, 3'd0, 8'hfd);
            8'h24: e = key_pair(3'd3, 8'hf7, 3'd0, 8'hfd);
            8'h25: e = key_pair(3'd3, 8'hef, 3'd0, 8'hfd);
            // break wins over the ampersand pairing
            8'h26: e = key_pair(3'd7, 8'hfe, 3'd0, 8'hfe);
            8'h27: e = key_pair(3'd4, 8'hf7, 3'd0, 8'hfd);
            8'h28: e = key_pair(3'd4, 8'hfb, 3'd0, 8'hfd);
            8'h29: e = key_pair(3'd4, 8'hfd, 3'd0, 8'hfd);
            8'h5f: e = key_pair(3'd4, 8'hfe, 3'd0, 8'hfd);
            // letters, upper case with shift
            8'h41: e = key_pair(3'd0, 8'hfe, 3'd1, 8'hfe);
            8'h61: e = key_single(3'd1, 8'hfe);
            8'h42: e = key_pair(3'd0, 8'hfe, 3'd7, 8'hf7);
            8'h62: e = key_single(3'd7, 8'hf7);
            8'h43: e = key_single(3'd0, 8'hee);
            8'h63: e = key_single(3'd0, 8'hef);
            8'h44: e = key_pair(3'd0, 8'hfe, 3'd1, 8'hfb);
            8'h64: e = key_single(3'd1, 8'hfb);
            8'h45: e = key_pair(3'd0, 8'hfe, 3'd2, 8'hfb);
            8'h65: e = key_single(3'd2, 8'hfb);
            8'h46: e = key_pair(3'd0, 8'hfe, 3'd1, 8'hf7);
            8'h66: e = key_single(3'd1, 8'hf7);
            8'h47: e = key_pair(3'd0, 8'hfe, 3'd1, 8'hef);
            8'h67: e = key_single(3'd1, 8'hef);
            8'h48: e = key_pair(3'd0, 8'hfe, 3'd6, 8'hef);
            8'h68: e = key_single(3'd6, 8'hef);
            8'h49: e = key_pair(3'd0, 8'hfe, 3'd5, 8'hfb);
            8'h69: e = key_single(3'd5, 8'hfb);
            8'h4a: e = key_pair(3'd0, 8'hfe, 3'd6, 8'hf7);
            8'h6a: e = key_single(3'd6, 8'hf7);
            8'h4b: e = key_pair(3'd0, 8'hfe, 3'd6, 8'hfb);
            8'h6b: e = key_single(3'd6, 8'hfb);
            8'h4c: e = key_pair(3'd0, 8'hfe, 3'd6, 8'hfd);
            8'h6c: e = key_single(3'd6, 8'hfd);
            8'h4d: e = key_pair(3'd0, 8'hfe, 3'd7, 8'hfd);
            8'h6d: e = key_single(3'd7, 8'hfd);
            8'h4e: e = key_pair(3'd0, 8'hfe, 3'd7, 8'hfb);
            8'h6e: e = key_single(3'd7, 8'hfb);
            8'h4f: e = key_pair(3'd0, 8'hfe, 3'd5, 8'hfd);
            8'h6f: e = key_single(3'd5, 8'hfd);
            8'h50: e = key_pair(3'd0, 8'hfe, 3'd5, 8'hfe);
            8'h70: e = key_single(3'd5, 8'hfe);
            8'h51: e = key_pair(3'd0, 8'hfe, 3'd2, 8'hfe);
            8'h71: e = key_single(3'd2, 8'hfe);
            8'h52: e = key_pair(3'd0, 8'hfe, 3'd2, 8'hf7);
            8'h72: e = key_single(3'd2, 8'hf7);
            8'h53: e = key_pair(3'd0, 8'hfe, 3'd1, 8'hfd);
            8'h73: e = key_single(3'd1, 8'hfd);
            8'h54: e = key_pair(3'd0, 8'hfe, 3'd2, 8'hef);
            8'h74: e = key_single(3'd2, 8'hef);
            8'h55: e = key_pair(3'd0, 8'hfe, 3'd5, 8'hf7);
            8'h75: e = key_single(3'd5, 8'hf7);
            8'h56: e = key_pair(3'd0, 8'hfe, 3'd7, 8'hef);
            8'h76: e = key_single(3'd7, 8'hef);
            8'h57: e = key_pair(3'd0, 8'hfe, 3'd2, 8'hfd);
            8'h77: e = key_single(3'd2, 8'hfd);
            8'h58: e = key_single(3'd0, 8'hf6);
            8'h78: e = key_single(3'd0, 8'hf7);
            8'h59: e = key_pair(3'd0, 8'hfe, 3'd5, 8'hef);
            8'h79: e = key_single(3'd5, 8'hef);
            8'h5a: e = key_single(3'd0, 8'hfa);
            8'h7a: e = key_single(3'd0, 8'hfb);
            // punctuation via symbol shift
            8'h3c: e = key_pair(3'd2, 8'hf7, 3'd0, 8'hfd);
            8'h3e: e = key_pair(3'd2, 8'hef, 3'd0, 8'hfd);
            8'h5b: e = key_pair(3'd5, 8'hef, 3'd0, 8'hfd);
            8'h5d: e = key_pair(3'd5, 8'hf7, 3'd0, 8'hfd);
            8'h60: e = key_pair(3'd5, 8'hfb, 3'd0, 8'hfd);
            8'h3b: e = key_pair(3'd5, 8'hfd, 3'd0, 8'hfd);
            8'h22: e = key_pair(3'd5, 8'hfe, 3'd0, 8'hfd);
            8'h7e: e = key_pair(3'd1, 8'hfe, 3'd0, 8'hfd);
            8'h7c: e = key_pair(3'd1, 8'hfd, 3'd0, 8'hfd);
            8'h5c: e = key_pair(3'd1, 8'hfb, 3'd0, 8'hfd);
            8'h7b: e = key_pair(3'd1, 8'hf7, 3'd0, 8'hfd);
            8'h7d: e = key_pair(3'd1, 8'hef, 3'd0, 8'hfd);
            8'h5e: e = key_pair(3'd6, 8'hef, 3'd0, 8'hfd);
            8'h2d: e = key_pair(3'd6, 8'hf7, 3'd0, 8'hfd);
            8'h2b: e = key_pair(3'd6, 8'hfb, 3'd0, 8'hfd);
            8'h3d: e = key_pair(3'd6, 8'hfd, 3'd0, 8'hfd);
            // enter, combined single-row keys and symbol shift on row 7
            8'h0a: e = key_single(3'd6, 8'hfe);
            8'h3a: e = key_single(3'd0, 8'hf9);
            8'h9c: e = key_single(3'd0, 8'hf5);
            8'h3f: e = key_single(3'd0, 8'hed);
            8'h2f: e = key_pair(3'd7, 8'hef, 3'd0, 8'hfd);
            8'h2a: e = key_pair(3'd7, 8'hf7, 3'd0, 8'hfd);
            8'h2c: e = key_pair(3'd7, 8'hfb, 3'd0, 8'hfd);
            8'h2e: e = key_pair(3'd7, 8'hfd, 3'd0, 8'hfd);
            // space and tab share the space key
            8'h20: e = key_single(3'd7, 8'hfe);
            8'h09: e = key_single(3'd7, 8'hfe);
            default: e.hit = 1'b0;
        endcase
        return e;
    endfunction

endpackage

// File: hw/rtl/kmr_opq.sv
// ----------------------------------------------------------------------------
// kmr_opq
// short operation queue between the decode front and the matrix back
// ----------------------------------------------------------------------------
module kmr_opq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  kmr_pkg::t_op  i_op,
    output logic          o_full,
    output logic          o_valid,
    output kmr_pkg::t_op  o_op,
    input  logic          i_pop
);

    kmr_pkg::t_op                   r_mem [kmr_pkg::OPQ_DEPTH];
    logic [kmr_pkg::OPQ_PTR_W-1:0]  r_wr;
    logic [kmr_pkg::OPQ_PTR_W-1:0]  n_wr;
    logic [kmr_pkg::OPQ_PTR_W-1:0]  r_rd;
    logic [kmr_pkg::OPQ_PTR_W-1:0]  n_rd;
    logic [kmr_pkg::OPQ_CNT_W-1:0]  r_cnt;
    logic [kmr_pkg::OPQ_CNT_W-1:0]  n_cnt;
    logic                           wr_en;
    logic                           rd_en;

    assign o_full  = (r_cnt == kmr_pkg::OPQ_CNT_W'(kmr_pkg::OPQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_mem[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (wr_en) begin
            n_wr = (r_wr == kmr_pkg::OPQ_PTR_W'(kmr_pkg::OPQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (rd_en) begin
            n_rd = (r_rd == kmr_pkg::OPQ_PTR_W'(kmr_pkg::OPQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({wr_en, rd_en})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_op;
        end
    end

endmodule

// File: hw/rtl/kmr_front.sv
// ----------------------------------------------------------------------------
// kmr_front
// accepts key events and row requests, decodes key codes into row masks
// ----------------------------------------------------------------------------
module kmr_front (
    input  logic                         i_push,
    output logic                         o_full,
    input  logic [kmr_pkg::MODE_W-1:0]   i_mode,
    input  logic [kmr_pkg::CODE_W-1:0]   i_key_code,
    input  logic [kmr_pkg::ROW_W-1:0]    i_port_index,
    input  logic                         i_q_full,
    output logic                         o_q_push,
    output kmr_pkg::t_op                 o_q_op
);

    kmr_pkg::t_key_entry entry;
    logic                accept;
    logic                keep;

    assign o_full = i_q_full;
    assign accept = i_push && !i_q_full;
    assign entry  = kmr_pkg::key_lookup(i_key_code);

    // unmapped press or release is swallowed here
    always_comb begin
        unique case (i_mode) inside
            kmr_pkg::MODE_PRESS,
            kmr_pkg::MODE_RELEASE: keep = entry.hit;
            kmr_pkg::MODE_READ,
            kmr_pkg::MODE_CLEAR:   keep = 1'b1;
            default:               keep = 1'b0;
        endcase
    end

    assign o_q_push          = accept && keep;
    assign o_q_op.mode       = i_mode;
    assign o_q_op.port_index = i_port_index;
    assign o_q_op.row_a      = entry.row_a;
    assign o_q_op.mask_a     = entry.mask_a;
    assign o_q_op.has_b      = entry.has_b;
    assign o_q_op.row_b      = entry.row_b;
    assign o_q_op.mask_b     = entry.mask_b;

endmodule

// File: hw/rtl/kmr_back.sv
// ----------------------------------------------------------------------------
// kmr_back
// holds the eight matrix rows, applies operations, registers row reads
// ----------------------------------------------------------------------------
module kmr_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  kmr_pkg::t_op                  i_op,
    output logic                          o_q_pop,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [kmr_pkg::DATA_W-1:0]    o_port_data
);

    logic [kmr_pkg::DATA_W-1:0] r_rows [kmr_pkg::ROW_COUNT];
    logic [kmr_pkg::DATA_W-1:0] n_rows [kmr_pkg::ROW_COUNT];
    logic                       r_out_valid;
    logic                       n_out_valid;
    logic [kmr_pkg::DATA_W-1:0] r_out_data;
    logic [kmr_pkg::DATA_W-1:0] n_out_data;
    logic                       is_read;
    logic                       stall;

    assign is_read = (i_op.mode == kmr_pkg::MODE_READ);
    // a read waits only while the output register still holds an untaken beat
    assign stall   = is_read && r_out_valid && !i_pop;
    assign o_q_pop = i_q_valid && !stall;

    always_comb begin
        for (int i = 0; i < kmr_pkg::ROW_COUNT; i++) begin
            n_rows[i] = r_rows[i];
            if (o_q_pop) begin
                unique case (i_op.mode)
                    kmr_pkg::MODE_PRESS: begin
                        if (i_op.row_a == kmr_pkg::ROW_W'(i)) begin
                            n_rows[i] = n_rows[i] & i_op.mask_a;
                        end
                        if (i_op.has_b && (i_op.row_b == kmr_pkg::ROW_W'(i))) begin
                            n_rows[i] = n_rows[i] & i_op.mask_b;
                        end
                    end
                    kmr_pkg::MODE_RELEASE: begin
                        if (i_op.row_a == kmr_pkg::ROW_W'(i)) begin
                            n_rows[i] = n_rows[i] | ~i_op.mask_a;
                        end
                        if (i_op.has_b && (i_op.row_b == kmr_pkg::ROW_W'(i))) begin
                            n_rows[i] = n_rows[i] | ~i_op.mask_b;
                        end
                    end
                    kmr_pkg::MODE_CLEAR: n_rows[i] = kmr_pkg::ROW_RESET;
                    default:             n_rows[i] = r_rows[i];
                endcase
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_pop;
        n_out_data  = r_out_data;
        if (o_q_pop && is_read) begin
            n_out_valid = 1'b1;
            n_out_data  = r_rows[i_op.port_index];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < kmr_pkg::ROW_COUNT; i++) begin
                r_rows[i] <= kmr_pkg::ROW_RESET;
            end
            r_out_valid <= 1'b0;
        end else begin
            r_rows      <= n_rows;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_empty     = !r_out_valid;
    assign o_port_data = r_out_data;

endmodule

// File: hw/rtl/key_to_matrix_row_mapper_top.sv
// ----------------------------------------------------------------------------
// key_to_matrix_row_mapper_top
// emulated keyboard matrix of eight active-low row bytes
//
// input queue side: push/full carry one beat of mode, key code and row index
//   (press, release, read row, clear all rows); a beat is taken when push is
//   high and full is low
// result queue side: empty/pop; only a row read gives a result beat, on
//   o_port_data while empty is low, taken when pop is high
// one beat per cycle is accepted while full is low; the front decodes the
//   key table in the accept cycle, and the back applies one operation per
//   cycle unless a read waits on the output register; a read result passes
//   through the operation queue and then the output register of the back,
//   which registers the row, before it can be popped
// reset (synchronous, active low) sets all rows to 0xff and empties both
//   the operation queue and the output register
// when the receiver stalls, the back applies press, release and clear beats
//   until a read heads the operation queue; it waits there until the output
//   register frees up, and full rises once the two-entry queue fills
// ----------------------------------------------------------------------------
module key_to_matrix_row_mapper_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [kmr_pkg::MODE_W-1:0]  i_mode,
    input  logic [kmr_pkg::CODE_W-1:0]  i_key_code,
    input  logic [kmr_pkg::ROW_W-1:0]   i_port_index,
    output logic                        empty,
    input  logic                        pop,
    output logic [kmr_pkg::DATA_W-1:0]  o_port_data
);

    // front to queue
    logic         q_full;
    logic         q_push;
    kmr_pkg::t_op q_in_op;

    // queue to back
    logic         q_valid;
    logic         q_pop;
    kmr_pkg::t_op q_out_op;

    // decode and classify, drop unmapped key events
    kmr_front u_front (
        .i_push       (push),
        .o_full       (full),
        .i_mode       (i_mode),
        .i_key_code   (i_key_code),
        .i_port_index (i_port_index),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_op       (q_in_op)
    );

    // decouples the decode side from the row update side
    kmr_opq u_opq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (q_in_op),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_op    (q_out_op),
        .i_pop   (q_pop)
    );

    // row state and output register
    kmr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_op        (q_out_op),
        .o_q_pop     (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_port_data (o_port_data)
    );

endmodule

// File: hw/rtl/kmr_checker.sv
// ----------------------------------------------------------------------------
// kmr_checker
// port-level checks of the key matrix mapper, bound to the top level
// ----------------------------------------------------------------------------
`include "key_to_matrix_row_mapper_top_defines.svh"

module kmr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        push,
    input logic                        full,
    input logic                        empty,
    input logic                        pop,
    input logic [kmr_pkg::DATA_W-1:0]  o_port_data
);

    // nothing waits on either side right after reset
    `KMR_ASSERT_IMP(a_empty_after_rst, i_clk, i_rst_n, $past(!i_rst_n), empty, "result after reset")
    `KMR_ASSERT_IMP(a_not_full_after_rst, i_clk, i_rst_n, $past(!i_rst_n), !full, "full after reset")

    // the queue only fills through an input beat
    `KMR_ASSERT_IMP(a_full_needs_push, i_clk, i_rst_n, $rose(full), $past(push), "full without push")

    // a waiting result holds until it is taken
    `KMR_ASSERT_NXT(a_result_holds, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_port_data), "result changed while waiting")

endmodule

bind key_to_matrix_row_mapper_top kmr_checker u_kmr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .push        (push),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_port_data (o_port_data)
);

// File: tb/key_to_matrix_row_mapper_top_tb.sv
// ----------------------------------------------------------------------------
// key_to_matrix_row_mapper_top_tb
// self-checking bench for the emulated keyboard matrix
//
// a short scripted sequence covers the field extremes, every mode, the break
// code, lowercase z, unmapped codes and inexact releases; a long random part
// follows, made mostly of presses and releases of mapped keys mixed with row
// reads. a local copy of the key map and the eight row bytes predicts every
// row read, and each result beat is checked against the oldest prediction
// ----------------------------------------------------------------------------
module key_to_matrix_row_mapper_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS  = 750;
    localparam int QUIET_LIMIT   = 1000;
    localparam int SCRIPT_LEN    = 24;
    localparam logic [3:0] NO_ROW = 4'hf;

    // one scripted beat; want is used only where has_want is set
    typedef struct {
        logic [kmr_pkg::MODE_W-1:0] mode;
        logic [kmr_pkg::CODE_W-1:0] code;
        logic [kmr_pkg::ROW_W-1:0]  row;
        bit                         has_want;
        logic [kmr_pkg::DATA_W-1:0] want;
    } t_key_beat;

    logic                         i_clk        = 1'b0;
    logic                         i_rst_n      = 1'b0;
    logic                         push         = 1'b0;
    logic                         pop          = 1'b0;
    logic [kmr_pkg::MODE_W-1:0]   i_mode       = kmr_pkg::MODE_PRESS;
    logic [kmr_pkg::CODE_W-1:0]   i_key_code   = '0;
    logic [kmr_pkg::ROW_W-1:0]    i_port_index = '0;
    logic                         full;
    logic                         empty;
    logic [kmr_pkg::DATA_W-1:0]   o_port_data;

    // predicted row bytes and the row reads still owed by the block
    logic [kmr_pkg::DATA_W-1:0]   kb_rows [kmr_pkg::ROW_COUNT];
    logic [kmr_pkg::DATA_W-1:0]   row_reads_due [$];
    logic [kmr_pkg::CODE_W-1:0]   held_keys [$];
    t_key_beat                    script [SCRIPT_LEN];

    int                  mismatch_count = 0;
    int                  quiet_cycles   = 0;
    bit                  steady_flow    = 1'b0;

    key_to_matrix_row_mapper_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_mode       (i_mode),
        .i_key_code   (i_key_code),
        .i_port_index (i_port_index),
        .empty        (empty),
        .pop          (pop),
        .o_port_data  (o_port_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // key map packed as {row_a, mask_a, row_b, mask_b}; a row of 4'hf means
    // no such pair, so an unmapped code has row_a == 4'hf
    function automatic logic [23:0] key_map_word(input logic [kmr_pkg::CODE_W-1:0] code);
        logic [23:0] w;
        w = 24'hf_ff_f_ff;
        case (code)
            // shifted control keys
            8'h01: w = 24'h3_fe_0_fe;   8'h02: w = 24'h3_f7_0_fe;
            8'h03: w = 24'h4_fd_0_fe;   8'h04: w = 24'h3_ef_0_fe;
            8'h05: w = 24'h4_f7_0_fe;   8'h06: w = 24'h4_ef_0_fe;
            8'h07: w = 24'h4_fb_0_fe;   8'h08: w = 24'h0_fe_4_fe;
            // digits
            8'h31: w = 24'h3_fe_f_ff;   8'h32: w = 24'h3_fd_f_ff;
            8'h33: w = 24'h3_fb_f_ff;   8'h34: w = 24'h3_f7_f_ff;
            8'h35: w = 24'h3_ef_f_ff;   8'h36: w = 24'h4_ef_f_ff;
            8'h37: w = 24'h4_f7_f_ff;   8'h38: w = 24'h4_fb_f_ff;
            8'h39: w = 24'h4_fd_f_ff;   8'h30: w = 24'h4_fe_f_ff;
            // symbol shift on the digit rows
            8'h21: w = 24'h3_fe_0_fd;   8'h40: w = 24'h3_fd_0_fd;
            8'h23: w = 24'h3_fb_0_fd;   8'h24: w = 24'h3_f7_0_fd;
            8'h25: w = 24'h3_ef_0_fd;
            // break, not ampersand
            8'h26: w = 24'h7_fe_0_fe;
            8'h27: w = 24'h4_f7_0_fd;   8'h28: w = 24'h4_fb_0_fd;
            8'h29: w = 24'h4_fd_0_fd;   8'h5f: w = 24'h4_fe_0_fd;
            // letters, upper case adds caps shift
            8'h41: w = 24'h0_fe_1_fe;   8'h61: w = 24'h1_fe_f_ff;
            8'h42: w = 24'h0_fe_7_f7;   8'h62: w = 24'h7_f7_f_ff;
            8'h43: w = 24'h0_ee_f_ff;   8'h63: w = 24'h0_ef_f_ff;
            8'h44: w = 24'h0_fe_1_fb;   8'h64: w = 24'h1_fb_f_ff;
            8'h45: w = 24'h0_fe_2_fb;   8'h65: w = 24'h2_fb_f_ff;
            8'h46: w = 24'h0_fe_1_f7;   8'h66: w = 24'h1_f7_f_ff;
            8'h47: w = 24'h0_fe_1_ef;   8'h67: w = 24'h1_ef_f_ff;
            8'h48: w = 24'h0_fe_6_ef;   8'h68: w = 24'h6_ef_f_ff;
            8'h49: w = 24'h0_fe_5_fb;   8'h69: w = 24'h5_fb_f_ff;
            8'h4a: w = 24'h0_fe_6_f7;   8'h6a: w = 24'h6_f7_f_ff;
            8'h4b: w = 24'h0_fe_6_fb;   8'h6b: w = 24'h6_fb_f_ff;
            8'h4c: w = 24'h0_fe_6_fd;   8'h6c: w = 24'h6_fd_f_ff;
            8'h4d: w = 24'h0_fe_7_fd;   8'h6d: w = 24'h7_fd_f_ff;
            8'h4e: w = 24'h0_fe_7_fb;   8'h6e: w = 24'h7_fb_f_ff;
            8'h4f: w = 24'h0_fe_5_fd;   8'h6f: w = 24'h5_fd_f_ff;
            8'h50: w = 24'h0_fe_5_fe;   8'h70: w = 24'h5_fe_f_ff;
            8'h51: w = 24'h0_fe_2_fe;   8'h71: w = 24'h2_fe_f_ff;
            8'h52: w = 24'h0_fe_2_f7;   8'h72: w = 24'h2_f7_f_ff;
            8'h53: w = 24'h0_fe_1_fd;   8'h73: w = 24'h1_fd_f_ff;
            8'h54: w = 24'h0_fe_2_ef;   8'h74: w = 24'h2_ef_f_ff;
            8'h55: w = 24'h0_fe_5_f7;   8'h75: w = 24'h5_f7_f_ff;
            8'h56: w = 24'h0_fe_7_ef;   8'h76: w = 24'h7_ef_f_ff;
            8'h57: w = 24'h0_fe_2_fd;   8'h77: w = 24'h2_fd_f_ff;
            8'h58: w = 24'h0_f6_f_ff;   8'h78: w = 24'h0_f7_f_ff;
            8'h59: w = 24'h0_fe_5_ef;   8'h79: w = 24'h5_ef_f_ff;
            8'h5a: w = 24'h0_fa_f_ff;   8'h7a: w = 24'h0_fb_f_ff;
            // punctuation on symbol shift
            8'h3c: w = 24'h2_f7_0_fd;   8'h3e: w = 24'h2_ef_0_fd;
            8'h5b: w = 24'h5_ef_0_fd;   8'h5d: w = 24'h5_f7_0_fd;
            8'h60: w = 24'h5_fb_0_fd;   8'h3b: w = 24'h5_fd_0_fd;
            8'h22: w = 24'h5_fe_0_fd;   8'h7e: w = 24'h1_fe_0_fd;
            8'h7c: w = 24'h1_fd_0_fd;   8'h5c: w = 24'h1_fb_0_fd;
            8'h7b: w = 24'h1_f7_0_fd;   8'h7d: w = 24'h1_ef_0_fd;
            8'h5e: w = 24'h6_ef_0_fd;   8'h2d: w = 24'h6_f7_0_fd;
            8'h2b: w = 24'h6_fb_0_fd;   8'h3d: w = 24'h6_fd_0_fd;
            // enter, combined single-row keys and symbol shift on row 7
            8'h0a: w = 24'h6_fe_f_ff;   8'h3a: w = 24'h0_f9_f_ff;
            8'h9c: w = 24'h0_f5_f_ff;   8'h3f: w = 24'h0_ed_f_ff;
            8'h2f: w = 24'h7_ef_0_fd;   8'h2a: w = 24'h7_f7_0_fd;
            8'h2c: w = 24'h7_fb_0_fd;   8'h2e: w = 24'h7_fd_0_fd;
            // space and tab hit the same key
            8'h20: w = 24'h7_fe_f_ff;   8'h09: w = 24'h7_fe_f_ff;
            default: w = 24'hf_ff_f_ff;
        endcase
        return w;
    endfunction

    function automatic bit key_is_mapped(input logic [kmr_pkg::CODE_W-1:0] code);
        logic [23:0] w;
        w = key_map_word(code);
        return w[23:20] != NO_ROW;
    endfunction

    function automatic logic [kmr_pkg::CODE_W-1:0] pick_mapped_key();
        logic [kmr_pkg::CODE_W-1:0] c;
        c = kmr_pkg::CODE_W'($urandom_range(255));
        while (!key_is_mapped(c)) c = kmr_pkg::CODE_W'($urandom_range(255));
        return c;
    endfunction

    // advance the predicted rows by one accepted beat
    task automatic matrix_apply(input logic [kmr_pkg::MODE_W-1:0] mode,
                                input logic [kmr_pkg::CODE_W-1:0] code,
                                input logic [kmr_pkg::ROW_W-1:0] row,
                                output bit gives_read,
                                output logic [kmr_pkg::DATA_W-1:0] read_val);
        logic [23:0] w;
        bit          is_press;
        w          = key_map_word(code);
        is_press   = (mode == kmr_pkg::MODE_PRESS);
        gives_read = 1'b0;
        read_val   = '0;
        case (mode) inside
            kmr_pkg::MODE_PRESS, kmr_pkg::MODE_RELEASE: begin
                if (w[23:20] != NO_ROW) begin
                    if (is_press) kb_rows[w[22:20]] &= w[19:12];
                    else          kb_rows[w[22:20]] |= ~w[19:12];
                    if (w[11:8] != NO_ROW) begin
                        if (is_press) kb_rows[w[10:8]] &= w[7:0];
                        else          kb_rows[w[10:8]] |= ~w[7:0];
                    end
                end
            end
            kmr_pkg::MODE_READ: begin
                gives_read = 1'b1;
                read_val   = kb_rows[row];
            end
            default: begin
                foreach (kb_rows[i]) kb_rows[i] = kmr_pkg::ROW_RESET;
            end
        endcase
    endtask

    // offer one beat, with random idle cycles in front of it outside the
    // steady stretch; push stays high from beat to beat when no idle falls
    task automatic send_key_beat(input logic [kmr_pkg::MODE_W-1:0] mode,
                                 input logic [kmr_pkg::CODE_W-1:0] code,
                                 input logic [kmr_pkg::ROW_W-1:0] row,
                                 input bit has_want,
                                 input logic [kmr_pkg::DATA_W-1:0] want);
        bit                         gives_read;
        logic [kmr_pkg::DATA_W-1:0] read_val;
        while (!steady_flow && $urandom_range(99) < 30) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push         <= 1'b1;
        i_mode       <= mode;
        i_key_code   <= code;
        i_port_index <= row;
        do @(posedge i_clk); while (full);
        matrix_apply(mode, code, row, gives_read, read_val);
        if (gives_read) row_reads_due.push_back(has_want ? want : read_val);
    endtask

    // receiver: pops at random, never idles in the steady stretch
    always @(posedge i_clk) begin
        pop <= steady_flow || ($urandom_range(99) >= 30);
    end

    // result check on every popped beat, oldest prediction first
    always @(posedge i_clk) begin : row_check
        logic [kmr_pkg::DATA_W-1:0] due;
        if (i_rst_n && pop && !empty) begin
            if (row_reads_due.size() == 0) begin
                $display("%0t: row beat with none pending, expected none, actual %02h",
                         $time, o_port_data);
                mismatch_count++;
            end else begin
                due = row_reads_due.pop_front();
                if (o_port_data !== due) begin
                    $display("%0t: port_data mismatch, expected %02h, actual %02h",
                             $time, due, o_port_data);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles in which neither side moves a beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        int                         counted;
        int                         r;
        logic [kmr_pkg::MODE_W-1:0] mode;
        logic [kmr_pkg::CODE_W-1:0] code;
        logic [kmr_pkg::ROW_W-1:0]  row;
        int                         slot;
        bit                         drained;

        foreach (kb_rows[i]) kb_rows[i] = kmr_pkg::ROW_RESET;
        drained = 1'b0;

        script = '{
            // rows read straight after reset, both row extremes
            '{kmr_pkg::MODE_READ,    8'h00, 3'd0, 1'b1, 8'hff},
            '{kmr_pkg::MODE_READ,    8'hff, 3'd7, 1'b1, 8'hff},
            // break takes the 0x26 code and clears bit 0 of rows 7 and 0
            '{kmr_pkg::MODE_PRESS,   8'h26, 3'd0, 1'b0, 8'h00},
            '{kmr_pkg::MODE_READ,    8'h00, 3'd7, 1'b1, 8'hfe},
            '{kmr_pkg::MODE_READ,    8'h00, 3'd0, 1'b1, 8'hfe},
            // release of a key never pressed still raises shared bits
            '{kmr_pkg::MODE_PRESS,   8'h43, 3'd7, 1'b0, 8'h00},
            '{kmr_pkg::MODE_RELEASE, 8'h41, 3'd0, 1'b0, 8'h00},
            '{kmr_pkg::MODE_READ,    8'h00, 3'd0, 1'b0, 8'h00},
            // 0x80 is unmapped, lowercase z sits at 0x7a
            '{kmr_pkg::MODE_PRESS,   8'h80, 3'd7, 1'b0, 8'h00},
            '{kmr_pkg::MODE_PRESS,   8'h7a, 3'd0, 1'b0, 8'h00},
            '{kmr_pkg::MODE_READ,    8'h80, 3'd0, 1'b0, 8'h00},
            // code extremes, both unmapped
            '{kmr_pkg::MODE_PRESS,   8'hff, 3'd7, 1'b0, 8'h00},
            '{kmr_pkg::MODE_RELEASE, 8'h00, 3'd0, 1'b0, 8'h00},
            '{kmr_pkg::MODE_RELEASE, 8'h26, 3'd3, 1'b0, 8'h00},
            '{kmr_pkg::MODE_PRESS,   8'h9c, 3'd0, 1'b0, 8'h00},
            '{kmr_pkg::MODE_PRESS,   8'h09, 3'd5, 1'b0, 8'h00},
            '{kmr_pkg::MODE_READ,    8'hff, 3'd7, 1'b0, 8'h00},
            // clear ignores its code and row fields
            '{kmr_pkg::MODE_CLEAR,   8'h41, 3'd5, 1'b0, 8'h00},
            '{kmr_pkg::MODE_READ,    8'h00, 3'd0, 1'b1, 8'hff},
            '{kmr_pkg::MODE_READ,    8'h00, 3'd3, 1'b1, 8'hff},
            '{kmr_pkg::MODE_PRESS,   8'h08, 3'd7, 1'b0, 8'h00},
            '{kmr_pkg::MODE_READ,    8'h00, 3'd4, 1'b0, 8'h00},
            '{kmr_pkg::MODE_RELEASE, 8'h08, 3'd0, 1'b0, 8'h00},
            '{kmr_pkg::MODE_READ,    8'hff, 3'd4, 1'b1, 8'hff}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i])
            send_key_beat(script[i].mode, script[i].code, script[i].row,
                          script[i].has_want, script[i].want);

        // random part: mostly presses and releases of mapped keys with row
        // reads in between; beats with unmapped codes are not counted
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            steady_flow = (counted >= 300 && counted < 450);
            r    = $urandom_range(99);
            code = kmr_pkg::CODE_W'($urandom_range(255));
            row  = kmr_pkg::ROW_W'($urandom_range(kmr_pkg::ROW_COUNT - 1));
            if (r < 35) begin
                mode = kmr_pkg::MODE_PRESS;
                code = pick_mapped_key();
                if (held_keys.size() < 8) held_keys.push_back(code);
            end else if (r < 55) begin
                mode = kmr_pkg::MODE_RELEASE;
                if (held_keys.size() != 0) begin
                    slot = $urandom_range(held_keys.size() - 1);
                    code = held_keys[slot];
                    held_keys.delete(slot);
                end else begin
                    code = pick_mapped_key();
                end
            end else if (r < 85) begin
                mode = kmr_pkg::MODE_READ;
            end else if (r < 88) begin
                mode = kmr_pkg::MODE_CLEAR;
                held_keys.delete();
            end else begin
                // noise: any code, mapped or not
                mode = ($urandom_range(1) != 0) ? kmr_pkg::MODE_RELEASE
                                                : kmr_pkg::MODE_PRESS;
            end
            send_key_beat(mode, code, row, 1'b0, '0);
            if (mode == kmr_pkg::MODE_READ || mode == kmr_pkg::MODE_CLEAR ||
                key_is_mapped(code))
                counted++;

            // once, hold the sender back until every pending read is out
            if (counted >= 550 && !drained && row_reads_due.size() != 0) begin
                drained = 1'b1;
                push <= 1'b0;
                while (row_reads_due.size() != 0) @(posedge i_clk);
            end
        end
        steady_flow = 1'b0;
        push <= 1'b0;

        while (row_reads_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/kmr_pkg.sv
hw/rtl/kmr_opq.sv
hw/rtl/kmr_front.sv
hw/rtl/kmr_back.sv
hw/rtl/key_to_matrix_row_mapper_top.sv
hw/rtl/kmr_checker.sv
tb/key_to_matrix_row_mapper_top_tb.sv
